FILE: hdl/mid_pkg.sv
// shared widths, codes and field encodings for the mips instruction decoder
package mid_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned MNEM_W   = 6;
  localparam int unsigned FORM_W   = 4;
  localparam int unsigned REG_W    = 5;
  localparam int unsigned SHAMT_W  = 5;
  localparam int unsigned IMM_W    = 16;
  localparam int unsigned TARGET_W = 26;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CODE_W   = 6;

  typedef enum logic [MNEM_W-1:0] {
    MN_NOP, MN_SLL, MN_BGEZ, MN_SRL, MN_SRA, MN_SLLV, MN_SRLV, MN_SRAV,
    MN_JR, MN_JALR, MN_MOVZ, MN_MOVN, MN_SYSCALL, MN_BREAK, MN_SYNC, MN_MFHI,
    MN_MTHI, MN_MFLO, MN_MTLO, MN_MULT, MN_MULTU, MN_DIV, MN_ADD, MN_ADDU,
    MN_SUB, MN_SUBU, MN_AND, MN_OR, MN_XOR, MN_NOR, MN_SLT, MN_SLTU,
    MN_TGE, MN_TGEU, MN_TLT, MN_TLTU, MN_TEQ, MN_TNE, MN_J, MN_JAL,
    MN_BEQ, MN_BNE, MN_BLEZ, MN_BGTZ, MN_ADDI, MN_ADDIU, MN_SLTI, MN_SLTIU,
    MN_ANDI, MN_ORI, MN_XORI, MN_LUI, MN_DIVU, MN_MUL, MN_LB, MN_LH,
    MN_LWL, MN_LW, MN_SB, MN_SH, MN_SWL, MN_SW, MN_SWR, MN_SC
  } mnem_t;

  typedef enum logic [FORM_W-1:0] {
    FORM_NONE, FORM_RD_RT_SH, FORM_RS_IMM, FORM_RD_RS_RT, FORM_TARGET,
    FORM_RD, FORM_RS, FORM_RS_RT, FORM_RS_RT_IMM, FORM_RT_RS_IMM,
    FORM_RT_IMM, FORM_RT_IMM_RS, FORM_RD_RS
  } form_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_FUNCT  = 2'd1,
    ST_BAD_OPCODE = 2'd2
  } status_t;

  // funct codes under the special opcode
  localparam logic [CODE_W-1:0] FN_SLL     = 6'd0;
  localparam logic [CODE_W-1:0] FN_BGEZ    = 6'd1;
  localparam logic [CODE_W-1:0] FN_SRL     = 6'd2;
  localparam logic [CODE_W-1:0] FN_SRA     = 6'd3;
  localparam logic [CODE_W-1:0] FN_SLLV    = 6'd4;
  localparam logic [CODE_W-1:0] FN_SRLV    = 6'd6;
  localparam logic [CODE_W-1:0] FN_SRAV    = 6'd7;
  localparam logic [CODE_W-1:0] FN_JR      = 6'd8;
  localparam logic [CODE_W-1:0] FN_JALR    = 6'd9;
  localparam logic [CODE_W-1:0] FN_MOVZ    = 6'd10;
  localparam logic [CODE_W-1:0] FN_MOVN    = 6'd11;
  localparam logic [CODE_W-1:0] FN_SYSCALL = 6'd12;
  localparam logic [CODE_W-1:0] FN_BREAK   = 6'd13;
  localparam logic [CODE_W-1:0] FN_SYNC    = 6'd15;
  localparam logic [CODE_W-1:0] FN_MFHI    = 6'd16;
  localparam logic [CODE_W-1:0] FN_MTHI    = 6'd17;
  localparam logic [CODE_W-1:0] FN_MFLO    = 6'd18;
  localparam logic [CODE_W-1:0] FN_MTLO    = 6'd19;
  localparam logic [CODE_W-1:0] FN_MULT    = 6'd24;
  localparam logic [CODE_W-1:0] FN_MULTU   = 6'd25;
  localparam logic [CODE_W-1:0] FN_DIV     = 6'd26;
  localparam logic [CODE_W-1:0] FN_ADD     = 6'd32;
  localparam logic [CODE_W-1:0] FN_ADDU    = 6'd33;
  localparam logic [CODE_W-1:0] FN_SUB     = 6'd34;
  localparam logic [CODE_W-1:0] FN_SUBU    = 6'd35;
  localparam logic [CODE_W-1:0] FN_AND     = 6'd36;
  localparam logic [CODE_W-1:0] FN_OR      = 6'd37;
  localparam logic [CODE_W-1:0] FN_XOR     = 6'd38;
  localparam logic [CODE_W-1:0] FN_NOR     = 6'd39;
  localparam logic [CODE_W-1:0] FN_SLT     = 6'd42;
  localparam logic [CODE_W-1:0] FN_SLTU    = 6'd43;
  localparam logic [CODE_W-1:0] FN_TGE     = 6'd48;
  localparam logic [CODE_W-1:0] FN_TGEU    = 6'd49;
  localparam logic [CODE_W-1:0] FN_TLT     = 6'd50;
  localparam logic [CODE_W-1:0] FN_TLTU    = 6'd51;
  localparam logic [CODE_W-1:0] FN_TEQ     = 6'd52;
  localparam logic [CODE_W-1:0] FN_TNE     = 6'd54;

  // primary opcodes
  localparam logic [CODE_W-1:0] OP_SPECIAL = 6'd0;
  localparam logic [CODE_W-1:0] OP_J       = 6'd2;
  localparam logic [CODE_W-1:0] OP_JAL     = 6'd3;
  localparam logic [CODE_W-1:0] OP_BEQ     = 6'd4;
  localparam logic [CODE_W-1:0] OP_BNE     = 6'd5;
  localparam logic [CODE_W-1:0] OP_BLEZ    = 6'd6;
  localparam logic [CODE_W-1:0] OP_BGTZ    = 6'd7;
  localparam logic [CODE_W-1:0] OP_ADDI    = 6'd8;
  localparam logic [CODE_W-1:0] OP_ADDIU   = 6'd9;
  localparam logic [CODE_W-1:0] OP_SLTI    = 6'd10;
  localparam logic [CODE_W-1:0] OP_SLTIU   = 6'd11;
  localparam logic [CODE_W-1:0] OP_ANDI    = 6'd12;
  localparam logic [CODE_W-1:0] OP_ORI     = 6'd13;
  localparam logic [CODE_W-1:0] OP_XORI    = 6'd14;
  localparam logic [CODE_W-1:0] OP_LUI     = 6'd15;
  localparam logic [CODE_W-1:0] OP_DIVU    = 6'd27;
  localparam logic [CODE_W-1:0] OP_MUL     = 6'd28;
  localparam logic [CODE_W-1:0] OP_LB      = 6'd32;
  localparam logic [CODE_W-1:0] OP_LH      = 6'd33;
  localparam logic [CODE_W-1:0] OP_LWL     = 6'd34;
  localparam logic [CODE_W-1:0] OP_LW      = 6'd35;
  localparam logic [CODE_W-1:0] OP_SB      = 6'd40;
  localparam logic [CODE_W-1:0] OP_SH      = 6'd41;
  localparam logic [CODE_W-1:0] OP_SWL     = 6'd42;
  localparam logic [CODE_W-1:0] OP_SW      = 6'd43;
  localparam logic [CODE_W-1:0] OP_SWR     = 6'd46;
  localparam logic [CODE_W-1:0] OP_SC      = 6'd56;

endpackage

FILE: hdl/mid_if.sv
// valid/ready channel interfaces for instruction beats and decode result beats
interface mid_instr_if;
  logic                            valid;
  logic                            ready;
  logic [mid_pkg::WORD_W-1:0]      instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink (input valid, input instruction_word, output ready);
endinterface

interface mid_result_if;
  logic                            valid;
  logic                            ready;
  logic [mid_pkg::MNEM_W-1:0]      mnemonic;
  logic [mid_pkg::FORM_W-1:0]      operand_form;
  logic [mid_pkg::REG_W-1:0]       source_reg;
  logic [mid_pkg::REG_W-1:0]       target_reg;
  logic [mid_pkg::REG_W-1:0]       dest_reg;
  logic [mid_pkg::SHAMT_W-1:0]     shift_amount;
  logic signed [mid_pkg::IMM_W-1:0] immediate;
  logic [mid_pkg::TARGET_W-1:0]    jump_target;
  logic [mid_pkg::STATUS_W-1:0]    status;

  modport source (
    output valid, output mnemonic, output operand_form, output source_reg,
    output target_reg, output dest_reg, output shift_amount, output immediate,
    output jump_target, output status, input ready
  );
  modport sink (
    input valid, input mnemonic, input operand_form, input source_reg,
    input target_reg, input dest_reg, input shift_amount, input immediate,
    input jump_target, input status, output ready
  );
endinterface

FILE: hdl/mips_instruction_decoder.sv
// mips32 instruction decoder: word register, table decode, result register
// each instruction beat passes the word register, then the result register
// throughput: one instruction per cycle unless result stalls, set by the single decode pass
// between the word register and the result register
// while a result beat is stalled an empty word register takes one more beat, then input stalls
// reset (rst, synchronous): both stages empty, payload registers not cleared
module mips_instruction_decoder (
  input  logic                clk,
  input  logic                rst,
  mid_instr_if.sink           instr,
  mid_result_if.source        result
);

  logic                             word_valid;
  logic [mid_pkg::WORD_W-1:0]       word;
  logic                             res_valid;
  logic                             res_room;
  logic                             advance;

  logic [mid_pkg::CODE_W-1:0]       opcode;
  logic [mid_pkg::CODE_W-1:0]       funct;
  logic                             regs_zero;
  mid_pkg::mnem_t                   mnem_next;
  mid_pkg::form_t                   form_next;
  mid_pkg::status_t                 status_next;

  mid_pkg::mnem_t                   mnemonic;
  mid_pkg::form_t                   operand_form;
  mid_pkg::status_t                 status;
  logic [mid_pkg::REG_W-1:0]        source_reg;
  logic [mid_pkg::REG_W-1:0]        target_reg;
  logic [mid_pkg::REG_W-1:0]        dest_reg;
  logic [mid_pkg::SHAMT_W-1:0]      shift_amount;
  logic signed [mid_pkg::IMM_W-1:0] immediate;
  logic [mid_pkg::TARGET_W-1:0]     jump_target;

  assign res_room    = !res_valid || result.ready;
  assign advance     = word_valid && res_room;
  assign instr.ready = !word_valid || res_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (instr.ready) begin
      word_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      word <= instr.instruction_word;
    end
  end

  assign opcode    = word[31:26];
  assign funct     = word[5:0];
  assign regs_zero = (word[25:11] == '0);

  always_comb begin
    mnem_next   = mid_pkg::MN_NOP;
    form_next   = mid_pkg::FORM_NONE;
    status_next = mid_pkg::ST_OK;
    if (opcode == mid_pkg::OP_SPECIAL) begin
      case (funct)
        mid_pkg::FN_SLL: begin
          if (!regs_zero) begin
            mnem_next = mid_pkg::MN_SLL;
            form_next = mid_pkg::FORM_RD_RT_SH;
          end
        end
        mid_pkg::FN_BGEZ: begin
          mnem_next = mid_pkg::MN_BGEZ;    form_next = mid_pkg::FORM_RS_IMM;
        end
        mid_pkg::FN_SRL: begin
          mnem_next = mid_pkg::MN_SRL;     form_next = mid_pkg::FORM_RD_RT_SH;
        end
        mid_pkg::FN_SRA: begin
          mnem_next = mid_pkg::MN_SRA;     form_next = mid_pkg::FORM_RD_RT_SH;
        end
        mid_pkg::FN_SLLV: begin
          mnem_next = mid_pkg::MN_SLLV;    form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_SRLV: begin
          mnem_next = mid_pkg::MN_SRLV;    form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_SRAV: begin
          mnem_next = mid_pkg::MN_SRAV;    form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_JR: begin
          mnem_next = mid_pkg::MN_JR;      form_next = mid_pkg::FORM_RS;
        end
        mid_pkg::FN_JALR: begin
          mnem_next = mid_pkg::MN_JALR;    form_next = mid_pkg::FORM_RD_RS;
        end
        mid_pkg::FN_MOVZ: begin
          mnem_next = mid_pkg::MN_MOVZ;    form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_MOVN: begin
          mnem_next = mid_pkg::MN_MOVN;    form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_SYSCALL: begin
          mnem_next = mid_pkg::MN_SYSCALL; form_next = mid_pkg::FORM_NONE;
        end
        mid_pkg::FN_BREAK: begin
          mnem_next = mid_pkg::MN_BREAK;   form_next = mid_pkg::FORM_NONE;
        end
        mid_pkg::FN_SYNC: begin
          mnem_next = mid_pkg::MN_SYNC;    form_next = mid_pkg::FORM_NONE;
        end
        mid_pkg::FN_MFHI: begin
          mnem_next = mid_pkg::MN_MFHI;    form_next = mid_pkg::FORM_RD;
        end
        mid_pkg::FN_MTHI: begin
          mnem_next = mid_pkg::MN_MTHI;    form_next = mid_pkg::FORM_RS;
        end
        mid_pkg::FN_MFLO: begin
          mnem_next = mid_pkg::MN_MFLO;    form_next = mid_pkg::FORM_RD;
        end
        mid_pkg::FN_MTLO: begin
          mnem_next = mid_pkg::MN_MTLO;    form_next = mid_pkg::FORM_RS;
        end
        mid_pkg::FN_MULT: begin
          mnem_next = mid_pkg::MN_MULT;    form_next = mid_pkg::FORM_RS_RT;
        end
        mid_pkg::FN_MULTU: begin
          mnem_next = mid_pkg::MN_MULTU;   form_next = mid_pkg::FORM_RS_RT;
        end
        mid_pkg::FN_DIV: begin
          mnem_next = mid_pkg::MN_DIV;     form_next = mid_pkg::FORM_RS_RT;
        end
        mid_pkg::FN_ADD: begin
          mnem_next = mid_pkg::MN_ADD;     form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_ADDU: begin
          mnem_next = mid_pkg::MN_ADDU;    form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_SUB: begin
          mnem_next = mid_pkg::MN_SUB;     form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_SUBU: begin
          mnem_next = mid_pkg::MN_SUBU;    form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_AND: begin
          mnem_next = mid_pkg::MN_AND;     form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_OR: begin
          mnem_next = mid_pkg::MN_OR;      form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_XOR: begin
          mnem_next = mid_pkg::MN_XOR;     form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_NOR: begin
          mnem_next = mid_pkg::MN_NOR;     form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_SLT: begin
          mnem_next = mid_pkg::MN_SLT;     form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_SLTU: begin
          mnem_next = mid_pkg::MN_SLTU;    form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::FN_TGE: begin
          mnem_next = mid_pkg::MN_TGE;     form_next = mid_pkg::FORM_RS_RT;
        end
        mid_pkg::FN_TGEU: begin
          mnem_next = mid_pkg::MN_TGEU;    form_next = mid_pkg::FORM_RS_RT;
        end
        mid_pkg::FN_TLT: begin
          mnem_next = mid_pkg::MN_TLT;     form_next = mid_pkg::FORM_RS_RT;
        end
        mid_pkg::FN_TLTU: begin
          mnem_next = mid_pkg::MN_TLTU;    form_next = mid_pkg::FORM_RS_RT;
        end
        mid_pkg::FN_TEQ: begin
          mnem_next = mid_pkg::MN_TEQ;     form_next = mid_pkg::FORM_RS_RT;
        end
        mid_pkg::FN_TNE: begin
          mnem_next = mid_pkg::MN_TNE;     form_next = mid_pkg::FORM_RS_RT;
        end
        default: begin
          status_next = mid_pkg::ST_BAD_FUNCT;
        end
      endcase
    end else begin
      case (opcode)
        mid_pkg::OP_J: begin
          mnem_next = mid_pkg::MN_J;       form_next = mid_pkg::FORM_TARGET;
        end
        mid_pkg::OP_JAL: begin
          mnem_next = mid_pkg::MN_JAL;     form_next = mid_pkg::FORM_TARGET;
        end
        mid_pkg::OP_BEQ: begin
          mnem_next = mid_pkg::MN_BEQ;     form_next = mid_pkg::FORM_RS_RT_IMM;
        end
        mid_pkg::OP_BNE: begin
          mnem_next = mid_pkg::MN_BNE;     form_next = mid_pkg::FORM_RS_RT_IMM;
        end
        mid_pkg::OP_BLEZ: begin
          mnem_next = mid_pkg::MN_BLEZ;    form_next = mid_pkg::FORM_RS_IMM;
        end
        mid_pkg::OP_BGTZ: begin
          mnem_next = mid_pkg::MN_BGTZ;    form_next = mid_pkg::FORM_RS_IMM;
        end
        mid_pkg::OP_ADDI: begin
          mnem_next = mid_pkg::MN_ADDI;    form_next = mid_pkg::FORM_RT_RS_IMM;
        end
        mid_pkg::OP_ADDIU: begin
          mnem_next = mid_pkg::MN_ADDIU;   form_next = mid_pkg::FORM_RT_RS_IMM;
        end
        mid_pkg::OP_SLTI: begin
          mnem_next = mid_pkg::MN_SLTI;    form_next = mid_pkg::FORM_RT_RS_IMM;
        end
        mid_pkg::OP_SLTIU: begin
          mnem_next = mid_pkg::MN_SLTIU;   form_next = mid_pkg::FORM_RT_RS_IMM;
        end
        mid_pkg::OP_ANDI: begin
          mnem_next = mid_pkg::MN_ANDI;    form_next = mid_pkg::FORM_RT_RS_IMM;
        end
        mid_pkg::OP_ORI: begin
          mnem_next = mid_pkg::MN_ORI;     form_next = mid_pkg::FORM_RT_RS_IMM;
        end
        mid_pkg::OP_XORI: begin
          mnem_next = mid_pkg::MN_XORI;    form_next = mid_pkg::FORM_RT_RS_IMM;
        end
        mid_pkg::OP_LUI: begin
          mnem_next = mid_pkg::MN_LUI;     form_next = mid_pkg::FORM_RT_IMM;
        end
        mid_pkg::OP_DIVU: begin
          mnem_next = mid_pkg::MN_DIVU;    form_next = mid_pkg::FORM_RS_RT;
        end
        mid_pkg::OP_MUL: begin
          mnem_next = mid_pkg::MN_MUL;     form_next = mid_pkg::FORM_RD_RS_RT;
        end
        mid_pkg::OP_LB: begin
          mnem_next = mid_pkg::MN_LB;      form_next = mid_pkg::FORM_RT_IMM_RS;
        end
        mid_pkg::OP_LH: begin
          mnem_next = mid_pkg::MN_LH;      form_next = mid_pkg::FORM_RT_IMM_RS;
        end
        mid_pkg::OP_LWL: begin
          mnem_next = mid_pkg::MN_LWL;     form_next = mid_pkg::FORM_RT_IMM_RS;
        end
        mid_pkg::OP_LW: begin
          mnem_next = mid_pkg::MN_LW;      form_next = mid_pkg::FORM_RT_IMM_RS;
        end
        mid_pkg::OP_SB: begin
          mnem_next = mid_pkg::MN_SB;      form_next = mid_pkg::FORM_RT_IMM_RS;
        end
        mid_pkg::OP_SH: begin
          mnem_next = mid_pkg::MN_SH;      form_next = mid_pkg::FORM_RT_IMM_RS;
        end
        mid_pkg::OP_SWL: begin
          mnem_next = mid_pkg::MN_SWL;     form_next = mid_pkg::FORM_RT_IMM_RS;
        end
        mid_pkg::OP_SW: begin
          mnem_next = mid_pkg::MN_SW;      form_next = mid_pkg::FORM_RT_IMM_RS;
        end
        mid_pkg::OP_SWR: begin
          mnem_next = mid_pkg::MN_SWR;     form_next = mid_pkg::FORM_RT_IMM_RS;
        end
        mid_pkg::OP_SC: begin
          mnem_next = mid_pkg::MN_SC;      form_next = mid_pkg::FORM_RT_IMM_RS;
        end
        default: begin
          status_next = mid_pkg::ST_BAD_OPCODE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_room) begin
      res_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mnemonic     <= mnem_next;
      operand_form <= form_next;
      status       <= status_next;
      source_reg   <= word[25:21];
      target_reg   <= word[20:16];
      dest_reg     <= word[15:11];
      shift_amount <= word[10:6];
      immediate    <= word[15:0];
      jump_target  <= word[25:0];
    end
  end

  assign result.valid        = res_valid;
  assign result.mnemonic     = mnemonic;
  assign result.operand_form = operand_form;
  assign result.status       = status;
  assign result.source_reg   = source_reg;
  assign result.target_reg   = target_reg;
  assign result.dest_reg     = dest_reg;
  assign result.shift_amount = shift_amount;
  assign result.immediate    = immediate;
  assign result.jump_target  = jump_target;

`ifndef SYNTH
  // failed decode reports no mnemonic and no form
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && status != mid_pkg::ST_OK) |->
      (mnemonic == mid_pkg::MN_NOP && operand_form == mid_pkg::FORM_NONE))
    else $error("failed decode carries a mnemonic or form");

  // nop only for the all-zero register fields
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == mid_pkg::ST_OK && mnemonic == mid_pkg::MN_NOP) |->
      (source_reg == '0 && target_reg == '0 && dest_reg == '0))
    else $error("nop decoded with nonzero register fields");

  // an accepted instruction beat always lands in the word register
  assert property (@(posedge clk) disable iff (rst)
    (instr.valid && instr.ready) |=> word_valid)
    else $error("instruction beat lost");

  // both stages full and the result stalled: no new beat taken
  assert property (@(posedge clk) disable iff (rst)
    (word_valid && res_valid && !result.ready) |-> !instr.ready)
    else $error("instruction beat taken with no room");

  // a held word moves on once the result stage has room
  assert property (@(posedge clk) disable iff (rst)
    (word_valid && res_room) |=> res_valid)
    else $error("decoded word did not reach result register");
`endif

endmodule
